// File: hw/rtl/lfu_cache_with_lru_tiebreak_macros.svh
// ----------------------------------------------------------------------------
// LFU cache assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_WITH_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_WITH_LRU_TIEBREAK_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define LFU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lfu assertion failed");

// next-cycle implication
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lfu assertion failed");

`else

`define LFU_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/lfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache package
// Shared constants, beat types and scan control types.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int CAP_W       = 5;
	localparam int DATA_W      = 32;

	localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
	localparam logic              OP_GET     = 1'b0;
	localparam logic              OP_PUT     = 1'b1;
	localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
	localparam logic [DATA_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;
	localparam logic [DATA_W-1:0] COUNT_ONE  = 32'd1;

	typedef struct packed {
		logic                     opcode;
		logic signed [DATA_W-1:0] lookup_key;
		logic signed [DATA_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] read_value;
		logic                     evicted;
		logic signed [DATA_W-1:0] evicted_key;
	} rsp_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] value;
		logic        [DATA_W-1:0] use_count;
		logic        [DATA_W-1:0] touch_stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic clr;  // start of a new lookup
		logic smp;  // read data valid this cycle
		logic vld;  // slot valid bit for the sampled entry
	} scan_ctl_t;

	typedef struct packed {
		logic match;
		logic victim;
		logic free;
	} scan_stat_t;

endpackage

// File: hw/rtl/lfu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lfu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/lfu_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU scan unit
// Takes one entry per cycle: key match, victim pick, free slot and fill count.
// ----------------------------------------------------------------------------
module lfu_scan #(
	parameter int ENTRIES = lfu_pkg::ENTRIES_DEF,
	parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lfu_pkg::scan_ctl_t        ctl,
	input  logic [IDX_W-1:0]          idx,
	input  logic signed [31:0]        key,
	input  lfu_pkg::entry_t           entry,
	output lfu_pkg::scan_stat_t       stat,
	output logic [IDX_W-1:0]          match_idx,
	output lfu_pkg::entry_t           match_entry,
	output logic [IDX_W-1:0]          victim_idx,
	output logic signed [31:0]        victim_key,
	output logic [IDX_W-1:0]          free_idx,
	output logic [CNT_W-1:0]          used
);
	import lfu_pkg::*;

	scan_stat_t         stat_q;
	logic [CNT_W-1:0]   used_q;
	logic [IDX_W-1:0]   match_idx_q, victim_idx_q, free_idx_q;
	entry_t             match_entry_q;
	logic [DATA_W-1:0]  best_cnt_q, best_stamp_q;
	logic signed [DATA_W-1:0] victim_key_q;
	logic               take_match, take_victim, take_free;

	// the one comparator set: key equality and (count, stamp) ordering
	always_comb begin
		take_match  = ctl.smp && ctl.vld && !stat_q.match && (entry.key == key);
		take_victim = ctl.smp && ctl.vld && (!stat_q.victim ||
			(entry.use_count < best_cnt_q) ||
			((entry.use_count == best_cnt_q) && (entry.touch_stamp < best_stamp_q)));
		take_free   = ctl.smp && !ctl.vld && !stat_q.free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= '0;
			used_q <= '0;
		end else if (ctl.clr) begin
			stat_q <= '0;
			used_q <= '0;
		end else begin
			if (take_match)  stat_q.match  <= 1'b1;
			if (take_victim) stat_q.victim <= 1'b1;
			if (take_free)   stat_q.free   <= 1'b1;
			if (ctl.smp && ctl.vld) used_q <= used_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take_match) begin
			match_idx_q   <= idx;
			match_entry_q <= entry;
		end
		if (take_victim) begin
			victim_idx_q <= idx;
			victim_key_q <= entry.key;
			best_cnt_q   <= entry.use_count;
			best_stamp_q <= entry.touch_stamp;
		end
		if (take_free) begin
			free_idx_q <= idx;
		end
	end

	assign stat        = stat_q;
	assign used        = used_q;
	assign match_idx   = match_idx_q;
	assign match_entry = match_entry_q;
	assign victim_idx  = victim_idx_q;
	assign victim_key  = victim_key_q;
	assign free_idx    = free_idx_q;

endmodule

// File: hw/rtl/lfu_cache_with_lru_tiebreak.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache with LRU tie-break
// Key-value cache, least-frequently-used replacement, oldest touch on ties.
// ----------------------------------------------------------------------------
// Usage:
//  - Request beat: drive req (opcode, lookup_key, write_value) with start high;
//    it is taken on a clock edge where busy is low. busy stays high until the
//    response has been produced.
//  - Response beat: rsp is valid for exactly one cycle while done is high.
//    The receiver cannot hold it off; capture it on that cycle.
//  - Sequence: after the accepting edge the block scans every entry, then
//    decides in ST_DECIDE; done is registered from that state. busy is low
//    in the done cycle, so the next request can be taken at the edge ending it.
//    The scan runs off the entry RAM: one entry is read per cycle through
//    a single read port into one shared match/victim comparator; the read
//    data is registered, then ST_DECIDE decides and writes back.
//  - Capacity register: cfg_data on cfg_valid (cfg_ready is always high).
//    Write it only between requests. Values above ENTRIES act as ENTRIES;
//    zero turns puts into no-ops.
//  - Reset: all slots invalid, stamp counter zero, capacity 16. The entry
//    RAM is not cleared; per-slot valid flops gate every read of it.
// ----------------------------------------------------------------------------
`include "lfu_cache_with_lru_tiebreak_macros.svh"

module lfu_cache_with_lru_tiebreak #(
	parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  lfu_pkg::req_t             req,
	output logic                      done,
	output lfu_pkg::rsp_t             rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lfu_pkg::CAP_W-1:0] cfg_data
);
	import lfu_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;

	logic [1:0]         state_q, state_d;
	req_t               req_q;
	logic [CAP_W-1:0]   cap_q;
	logic [DATA_W-1:0]  stamp_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   rd_cnt_q;
	logic               samp_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               done_q;
	rsp_t               rsp_q, rsp_d;

	logic               accept, rd_issue, last_s1;
	logic               wr_en, ram_we, set_vld;
	logic [IDX_W-1:0]   wr_idx;
	entry_t             wr_entry, rd_entry, bumped;

	scan_ctl_t          sc_ctl;
	scan_stat_t         sc_stat;
	logic [IDX_W-1:0]   match_idx, victim_idx, free_idx;
	entry_t             match_entry;
	logic signed [DATA_W-1:0] victim_key;
	logic [CNT_W-1:0]   used;

	logic [CMP_W-1:0]   cap_ext, cap_lim;
	logic               full, cap_zero;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign rd_issue  = (state_q == ST_SCAN) && (rd_cnt_q != CNT_W'(ENTRIES));
	assign last_s1   = samp_s1 && (idx_s1 == IDX_W'(ENTRIES - 1));

	// ---- capacity clamp and fill check ----
	assign cap_ext  = CMP_W'(cap_q);
	assign cap_lim  = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
	assign cap_zero = (cap_q == '0);
	assign full     = (CMP_W'(used) >= cap_lim);

	// ---- sequencer ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = ST_SCAN;
			ST_SCAN:   if (last_s1) state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// ---- decide: response and write-back, all from scan results ----
	always_comb begin
		bumped             = match_entry;
		bumped.use_count   = (match_entry.use_count == COUNT_MAX) ?
			COUNT_MAX : match_entry.use_count + 32'd1;
		bumped.touch_stamp = stamp_q;
		wr_en    = 1'b0;
		set_vld  = 1'b0;
		wr_idx   = match_idx;
		wr_entry = bumped;
		rsp_d    = '0;
		rsp_d.hit = sc_stat.match;
		if (req_q.opcode == OP_GET) begin
			if (sc_stat.match) begin
				rsp_d.read_value = match_entry.value;
				wr_en = 1'b1;
			end else begin
				rsp_d.read_value = MISS_VALUE;
			end
		end else if (!cap_zero) begin
			wr_en = 1'b1;
			if (sc_stat.match) begin
				wr_entry.value = req_q.write_value;
			end else begin
				set_vld  = 1'b1;
				wr_entry = '{key: req_q.lookup_key, value: req_q.write_value,
					use_count: COUNT_ONE, touch_stamp: stamp_q};
				if (full && sc_stat.victim) begin
					// reuse the victim's slot
					wr_idx            = victim_idx;
					rsp_d.evicted     = 1'b1;
					rsp_d.evicted_key = victim_key;
				end else begin
					wr_idx = free_idx;
				end
			end
		end
	end

	assign ram_we = (state_q == ST_DECIDE) && wr_en;

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cap_q    <= CAP_RESET;
			stamp_q  <= '0;
			valid_q  <= '0;
			rd_cnt_q <= '0;
			samp_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			samp_s1 <= rd_issue;
			done_q  <= (state_q == ST_DECIDE);
			if (cfg_valid && cfg_ready) cap_q <= cfg_data;
			if (accept) begin
				rd_cnt_q <= '0;
			end else if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			if (ram_we) begin
				stamp_q <= stamp_q + 32'd1;
				if (set_vld) valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (accept) req_q <= req;
		idx_s1 <= rd_cnt_q[IDX_W-1:0];
		if (state_q == ST_DECIDE) rsp_q <= rsp_d;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// ---- entry store ----
	lfu_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx),
		.wdata (wr_entry),
		.raddr (rd_cnt_q[IDX_W-1:0]),
		.rdata (rd_entry)
	);

	assign sc_ctl = '{clr: accept, smp: samp_s1, vld: valid_q[idx_s1]};

	lfu_scan #(
		.ENTRIES (ENTRIES)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (sc_ctl),
		.idx         (idx_s1),
		.key         (req_q.lookup_key),
		.entry       (rd_entry),
		.stat        (sc_stat),
		.match_idx   (match_idx),
		.match_entry (match_entry),
		.victim_idx  (victim_idx),
		.victim_key  (victim_key),
		.free_idx    (free_idx),
		.used        (used)
	);

	// ---- checks ----
	`LFU_ASSERT_NEXT(a_decide_then_done, clk, arst_n, state_q == ST_DECIDE, done)
	`LFU_ASSERT_IMPLY(a_evict_only_on_miss, clk, arst_n, done && rsp.evicted, !rsp.hit)
	`LFU_ASSERT_NEXT(a_accept_goes_busy, clk, arst_n, accept, busy && !done)
	`LFU_ASSERT_NEXT(a_write_bumps_stamp, clk, arst_n, ram_we, stamp_q == $past(stamp_q) + 32'd1)

endmodule
